// ===== hdl/rcc_pkg.sv =====
// Shared constants and types for the RGBA 3x3 convolution block.
`timescale 1ns / 1ps

package rcc_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROWC_W     = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 12;
  localparam int CMP_W      = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
  localparam int ROWC_CMP_W = ((ROWC_W > DIM_W) ? ROWC_W : DIM_W) + 1;
  localparam int MIN_DIM    = 3;

  // Pixel and kernel formats
  localparam int PIX_W      = 8;
  localparam int RGBA_W     = 4 * PIX_W;
  localparam int CHANNELS   = 3;
  localparam int TAPS       = 9;
  localparam int WIN_SIDE   = 3;
  localparam int WGT_W      = 16;
  localparam int KROW_W     = WIN_SIDE * WGT_W;
  localparam int PROD_W     = WGT_W + PIX_W + 1;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int TSUM_W     = RSUM_W + 2;
  localparam int FRAC_W     = 8;
  localparam int PIX_MAX    = (1 << PIX_W) - 1;
  localparam int SAT_LIMIT  = PIX_MAX << FRAC_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 3'd0,
    CFG_LINE_COUNT = 3'd1,
    CFG_KERN_TOP   = 3'd2,
    CFG_KERN_MID   = 3'd3,
    CFG_KERN_BOT   = 3'd4
  } cfg_idx_t;

  localparam logic [KROW_W-1:0] KERN_TOP_RST = '0;
  localparam logic [KROW_W-1:0] KERN_MID_RST = KROW_W'(1 << (WGT_W + FRAC_W));
  localparam logic [KROW_W-1:0] KERN_BOT_RST = '0;
  localparam logic [DIM_W-1:0]  WIDTH_RST    = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RST   = DIM_W'(480);

  typedef logic [RGBA_W-1:0]        rgba_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;
  typedef logic signed [TSUM_W-1:0] tsum_t;

endpackage

// ===== hdl/rcc_if.sv =====
// Valid/ready channel interfaces for input pixels and convolved result pixels.
`timescale 1ns / 1ps

interface rcc_in_if import rcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_red;
  logic [PIX_W-1:0] pix_green;
  logic [PIX_W-1:0] pix_blue;
  logic [PIX_W-1:0] pix_alpha;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  output pix_alpha, input ready);
  modport sink   (input valid, input pix_red, input pix_green, input pix_blue,
                  input pix_alpha, output ready);
endinterface

interface rcc_out_if import rcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_alpha;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output row_end, output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, input row_end, input frame_end, output ready);
endinterface

// ===== hdl/rgba_3x3_convolution_clamp.sv =====
// Top level: streaming 3x3 RGBA convolution with line stores and clamped output.
`timescale 1ns / 1ps

// Usage
//   in_pix  : RGBA pixels in raster order, one request per pixel (valid/ready).
//   out_pix : one request per full 3x3 window, so (W-2) x (H-2) per frame, with
//             row_end on the last pixel of an output row and frame_end on the last
//             pixel of the frame. R, G, B are clamped to 0..255, fraction dropped;
//             alpha is the window's top-left alpha.
//   cfg_*   : write line_width, line_count and the three Q8.8 kernel rows while
//             the block is idle. Widths/heights are clamped to 3..2048 internally.
// Path: the request that completes a window passes the read stage, window stage,
//   multiply, row sum and final sum before its result is valid.
// Throughput: one pixel per cycle while the receiver keeps up. Each line store
//   does one read (at acceptance) and one write-back (one stage later) per pixel;
//   the same column comes back a full row later, so read and write never collide.
// Reset: counters to zero, kernel to identity, 640 x 480. The line stores are not
//   cleared; every entry a window reads has been written earlier in the frame.
// Stall: a stalled receiver holds the output register; stages fill behind it
//   and in_pix.ready drops only when all five stages hold a request.

module rgba_3x3_convolution_clamp import rcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rcc_in_if.sink                in_pix,
  rcc_out_if.source             out_pix
);

  // Configuration registers
  logic [DIM_W-1:0]  line_width_r, line_count_r;
  logic [KROW_W-1:0] kern_r [WIN_SIDE];

  // Position counters
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROWC_W-1:0] row_cnt_r, row_cnt_nxt;

  // Line stores and their registered read data
  rgba_t upper_mem [MAX_WIDTH];
  rgba_t lower_mem [MAX_WIDTH];
  rgba_t up_rd_r, mid_rd_r;

  // Stage 1: memory read returns
  logic             s1_v_r, s1_v_nxt;
  rgba_t            s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_emit_r, s1_row_end_r, s1_frame_end_r;

  // Stage 2: window
  logic             s2_v_r, s2_v_nxt;
  rgba_t            win_r [TAPS];
  logic             s2_row_end_r, s2_frame_end_r;

  // Stage 3: products
  logic             s3_v_r, s3_v_nxt;
  prod_t            prod_r   [CHANNELS][TAPS];
  prod_t            prod_nxt [CHANNELS][TAPS];
  logic [PIX_W-1:0] s3_alpha_r;
  logic             s3_row_end_r, s3_frame_end_r;

  // Stage 4: row sums
  logic             s4_v_r, s4_v_nxt;
  rsum_t            rsum_r   [CHANNELS][WIN_SIDE];
  rsum_t            rsum_nxt [CHANNELS][WIN_SIDE];
  logic [PIX_W-1:0] s4_alpha_r;
  logic             s4_row_end_r, s4_frame_end_r;

  // Output register
  logic             out_v_r, out_v_nxt;
  logic [PIX_W-1:0] out_chan_r   [CHANNELS];
  logic [PIX_W-1:0] out_chan_nxt [CHANNELS];
  logic [PIX_W-1:0] out_alpha_r;
  logic             out_row_end_r, out_frame_end_r;

  // Handshake chain
  logic rdy2, rdy3, rdy4, rdy5;
  logic in_ready, in_fire, s1_fire, s2_fire, s3_fire, s4_fire;

  // Geometry decode
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             last_col, last_row, emit;
  rgba_t            in_rgba;

  // ---------------------------------------------------------------------------
  // Handshake: each stage advances when the one after it is empty or advancing.
  // ---------------------------------------------------------------------------
  always_comb begin
    rdy5     = !out_v_r || out_pix.ready;
    rdy4     = !s4_v_r || rdy5;
    rdy3     = !s3_v_r || rdy4;
    rdy2     = !s2_v_r || rdy3;
    in_ready = !s1_v_r || rdy2;
    in_fire  = in_pix.valid && in_ready;
    s1_fire  = s1_v_r && rdy2;
    s2_fire  = s2_v_r && rdy3;
    s3_fire  = s3_v_r && rdy4;
    s4_fire  = s4_v_r && rdy5;
  end

  assign in_pix.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WIDTH_RST;
      line_count_r <= HEIGHT_RST;
      kern_r[0]    <= KERN_TOP_RST;
      kern_r[1]    <= KERN_MID_RST;
      kern_r[2]    <= KERN_BOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_WIDTH: line_width_r <= cfg_wdata[DIM_W-1:0];
        CFG_LINE_COUNT: line_count_r <= cfg_wdata[DIM_W-1:0];
        CFG_KERN_TOP:   kern_r[0]    <= cfg_wdata[KROW_W-1:0];
        CFG_KERN_MID:   kern_r[1]    <= cfg_wdata[KROW_W-1:0];
        CFG_KERN_BOT:   kern_r[2]    <= cfg_wdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: clamp the frame size, classify the incoming pixel, step counters.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (line_width_r < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (CMP_W'(line_width_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width_r;
    end
    if (line_count_r < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (ROWC_CMP_W'(line_count_r) > ROWC_CMP_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = line_count_r;
    end

    // compare with >= so a size change mid-frame still ends the row
    last_col = CMP_W'(col_cnt_r) >= CMP_W'(w_eff - DIM_W'(1));
    last_row = ROWC_CMP_W'(row_cnt_r) >= ROWC_CMP_W'(h_eff - DIM_W'(1));
    emit     = (col_cnt_r >= COL_W'(2)) && (row_cnt_r >= ROWC_W'(2));

    in_rgba  = {in_pix.pix_alpha, in_pix.pix_blue, in_pix.pix_green, in_pix.pix_red};

    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_fire) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + ROWC_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  // Line stores: read at acceptance, write back from stage 1.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      up_rd_r <= upper_mem[col_cnt_r];
    end
    if (s1_fire) begin
      upper_mem[s1_col_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mid_rd_r <= lower_mem[col_cnt_r];
    end
    if (s1_fire) begin
      lower_mem[s1_col_r] <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic: products, row sums, final sum with clamp.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_nxt[ch][k] =
          $signed(kern_r[k / WIN_SIDE][(k % WIN_SIDE) * WGT_W +: WGT_W]) *
          $signed({1'b0, win_r[k][ch * PIX_W +: PIX_W]});
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int r = 0; r < WIN_SIDE; r++) begin
        rsum_nxt[ch][r] = RSUM_W'(prod_r[ch][r * WIN_SIDE])
                        + RSUM_W'(prod_r[ch][r * WIN_SIDE + 1])
                        + RSUM_W'(prod_r[ch][r * WIN_SIDE + 2]);
      end
    end
  end

  always_comb begin
    tsum_t total;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      total = TSUM_W'(rsum_r[ch][0]) + TSUM_W'(rsum_r[ch][1]) + TSUM_W'(rsum_r[ch][2]);
      // saturate low at zero, high at 255.0, else drop the fraction
      if (total <= 0) begin
        out_chan_nxt[ch] = '0;
      end else if (total >= TSUM_W'(SAT_LIMIT)) begin
        out_chan_nxt[ch] = PIX_W'(PIX_MAX);
      end else begin
        out_chan_nxt[ch] = total[FRAC_W +: PIX_W];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids. Pixels that close no window are dropped after the window.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_v_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_fire ? s1_emit_r : (s2_fire ? 1'b0 : s2_v_r);
    s3_v_nxt  = s2_fire ? 1'b1 : (s3_fire ? 1'b0 : s3_v_r);
    s4_v_nxt  = s3_fire ? 1'b1 : (s4_fire ? 1'b0 : s4_v_r);
    out_v_nxt = s4_fire ? 1'b1 : ((out_v_r && out_pix.ready) ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      s3_v_r    <= s3_v_nxt;
      s4_v_r    <= s4_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r       <= in_rgba;
      s1_col_r       <= col_cnt_r;
      s1_emit_r      <= emit;
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
    end
    if (s1_fire) begin
      // shift the window left, new column enters on the right
      for (int r = 0; r < WIN_SIDE; r++) begin
        win_r[r * WIN_SIDE]     <= win_r[r * WIN_SIDE + 1];
        win_r[r * WIN_SIDE + 1] <= win_r[r * WIN_SIDE + 2];
      end
      win_r[2]       <= up_rd_r;
      win_r[5]       <= mid_rd_r;
      win_r[8]       <= s1_pix_r;
      s2_row_end_r   <= s1_row_end_r;
      s2_frame_end_r <= s1_frame_end_r;
    end
    if (s2_fire) begin
      prod_r         <= prod_nxt;
      s3_alpha_r     <= win_r[0][3 * PIX_W +: PIX_W];
      s3_row_end_r   <= s2_row_end_r;
      s3_frame_end_r <= s2_frame_end_r;
    end
    if (s3_fire) begin
      rsum_r         <= rsum_nxt;
      s4_alpha_r     <= s3_alpha_r;
      s4_row_end_r   <= s3_row_end_r;
      s4_frame_end_r <= s3_frame_end_r;
    end
    if (s4_fire) begin
      out_chan_r      <= out_chan_nxt;
      out_alpha_r     <= s4_alpha_r;
      out_row_end_r   <= s4_row_end_r;
      out_frame_end_r <= s4_frame_end_r;
    end
  end

  assign out_pix.valid     = out_v_r;
  assign out_pix.out_red   = out_chan_r[0];
  assign out_pix.out_green = out_chan_r[1];
  assign out_pix.out_blue  = out_chan_r[2];
  assign out_pix.out_alpha = out_alpha_r;
  assign out_pix.row_end   = out_row_end_r;
  assign out_pix.frame_end = out_frame_end_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_rw_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_fire) |-> (col_cnt_r != s1_col_r))
    else $error("line store read and write-back hit the same column");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_frame_end_r || out_row_end_r))
    else $error("frame end without row end");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_v_r && !out_pix.ready))
    else $error("input held off with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !s1_v_r))
    else $error("pipeline not empty after reset");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the streaming RGBA 3x3 convolution block.
`timescale 1ns / 1ps

// Drives raster-order pixel streams through rgba_3x3_convolution_clamp and predicts each
// result pixel in a scoreboard class that keeps its own line stores, window, counters and
// register copies. Covers the reset kernel and height on a narrow frame, a mid-frame shrink
// of both dimensions, rounding and clamping corners of the Q8.8 kernel, oversize sizes that
// clamp to the maximum, and random frames with random kernels. Both sides of the stream
// idle at random.

module tb;
  import rcc_pkg::*;

  localparam int          SETTLE_CYCLES = 8;     // pipeline depth plus margin
  localparam int          RANDOM_ITEMS  = 200;
  localparam int          START_WIDTH   = 12;
  localparam int          START_ITEMS   = 13 * START_WIDTH + 8;  // ends at row 13, column 7
  localparam int          WIDE_ITEMS    = 64;
  localparam int          TALL_ITEMS    = 60;
  localparam int          LONG_HOLD     = 80;    // receiver hold-off, long enough to fill up
  localparam int          HOLD_AFTER    = 30;    // results checked before the hold-off
  localparam int          REG_COUNT     = 5;
  localparam int unsigned NO_LIMIT      = 32'hFFFF_FFFF;

  localparam logic [WGT_W-1:0] WGT_ONE     = 16'h0100;  // 1.0
  localparam logic [WGT_W-1:0] WGT_UNDER   = 16'h00FF;  // just below 1.0
  localparam logic [WGT_W-1:0] WGT_NEG_LSB = 16'hFFFF;  // -1/256
  localparam logic [WGT_W-1:0] WGT_POS_MAX = 16'h7FFF;
  localparam logic [WGT_W-1:0] WGT_NEG_MAX = 16'h8000;
  localparam logic [DIM_W-1:0] DIM_FIELD_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0] alpha, blue, green, red;
  } pixel_t;

  typedef struct {
    logic [PIX_W-1:0] red, green, blue, alpha;
    logic             row_end, frame_end;
  } conv_result_t;

  typedef logic [CFG_DATA_W-1:0] reg_image_t [REG_COUNT];

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_DARK} pix_style_t;
  typedef enum {KERN_SOFT, KERN_WIDE, KERN_EDGE} kern_style_t;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_LIGHT, SINK_BEAT} sink_mode_t;

  // Convolution predictor and store of expected result pixels.
  class conv_scoreboard;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [KROW_W-1:0] kern_row [WIN_SIDE];
    rgba_t             upper_row [MAX_WIDTH];
    rgba_t             lower_row [MAX_WIDTH];
    rgba_t             win_px [TAPS];
    logic [COL_W-1:0]  col_cnt;
    logic [ROWC_W-1:0] row_cnt;
    conv_result_t      expected_q [$];
    int unsigned       accepted, frames_done, checked, errors;

    function new();
      width_reg   = WIDTH_RST;
      height_reg  = HEIGHT_RST;
      kern_row[0] = KERN_TOP_RST;
      kern_row[1] = KERN_MID_RST;
      kern_row[2] = KERN_BOT_RST;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win_px[i]) win_px[i] = '0;
      col_cnt     = '0;
      row_cnt     = '0;
      accepted    = 0;
      frames_done = 0;
      checked     = 0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LINE_WIDTH: width_reg = data[DIM_W-1:0];
        CFG_LINE_COUNT: height_reg = data[DIM_W-1:0];
        CFG_KERN_TOP:   kern_row[0] = data;
        CFG_KERN_MID:   kern_row[1] = data;
        CFG_KERN_BOT:   kern_row[2] = data;
        default: ;
      endcase
    endfunction

    function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned top);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > top) return top;
      return 32'(v);
    endfunction

    function logic [PIX_W-1:0] channel_sum(int unsigned ch);
      longint                  acc;
      logic signed [WGT_W-1:0] wgt;
      acc = 0;
      for (int r = 0; r < WIN_SIDE; r++) begin
        for (int c = 0; c < WIN_SIDE; c++) begin
          wgt = kern_row[r][WGT_W*c +: WGT_W];
          acc += longint'(wgt) * longint'(win_px[r*WIN_SIDE+c][PIX_W*ch +: PIX_W]);
        end
      end
      if (acc <= 0) return '0;
      if (acc >= SAT_LIMIT) return PIX_W'(PIX_MAX);
      return acc[FRAC_W +: PIX_W];
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned  w, h;
      rgba_t        up, mid;
      bit           last_col, last_row;
      conv_result_t res;
      w        = eff_dim(width_reg, MAX_WIDTH);
      h        = eff_dim(height_reg, MAX_HEIGHT);
      up       = upper_row[col_cnt];
      mid      = lower_row[col_cnt];
      last_col = (col_cnt >= w - 1);
      last_row = (row_cnt >= h - 1);
      upper_row[col_cnt] = mid;
      lower_row[col_cnt] = p;
      for (int r = 0; r < WIN_SIDE; r++) begin
        win_px[r*WIN_SIDE]   = win_px[r*WIN_SIDE+1];
        win_px[r*WIN_SIDE+1] = win_px[r*WIN_SIDE+2];
      end
      win_px[WIN_SIDE-1]   = up;
      win_px[2*WIN_SIDE-1] = mid;
      win_px[TAPS-1]       = p;
      accepted++;
      if (col_cnt >= 2 && row_cnt >= 2) begin
        res.red       = channel_sum(0);
        res.green     = channel_sum(1);
        res.blue      = channel_sum(2);
        res.alpha     = win_px[0][RGBA_W-1 -: PIX_W];
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;
        expected_q.push_back(res);
      end
      if (last_col) begin
        col_cnt = '0;
        if (last_row) begin
          row_cnt = '0;
          frames_done++;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(conv_result_t got);
      conv_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: rgba %0d %0d %0d %0d, ends %0b %0b",
                 $time, got.red, got.green, got.blue, got.alpha, got.row_end, got.frame_end);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_alpha", want.alpha, got.alpha);
      compare_field("row_end", PIX_W'(want.row_end), PIX_W'(got.row_end));
      compare_field("frame_end", PIX_W'(want.frame_end), PIX_W'(got.frame_end));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rcc_in_if  in_pix ();
  rcc_out_if out_pix ();

  conv_scoreboard sb = new();

  // Stimulus shaping, changed per phase
  pix_style_t pix_style;
  bit         sender_gaps;

  rgba_3x3_convolution_clamp DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .out_pix   (out_pix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Pixel content for the current phase. Dark pixels keep red, green and blue below 32.
  function automatic pixel_t make_pixel();
    pixel_t p;
    p = $urandom;
    case (pix_style)
      PIX_EXTREME: begin
        for (int i = 0; i < 4; i++) p[PIX_W*i +: PIX_W] = $urandom_range(0, 1) ? '1 : '0;
      end
      PIX_DARK: begin
        p.red   = p.red >> 3;
        p.green = p.green >> 3;
        p.blue  = p.blue >> 3;
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [WGT_W-1:0] make_weight(kern_style_t ks);
    logic [WGT_W-1:0] picks [5];
    picks = '{WGT_POS_MAX, WGT_NEG_MAX, '0, WGT_ONE, WGT_NEG_LSB};
    case (ks)
      KERN_SOFT: return WGT_W'($urandom_range(0, 512) - 256);  // -1.0 .. +1.0
      KERN_WIDE: return WGT_W'($urandom);
      default:   return picks[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] make_row(kern_style_t ks);
    return {make_weight(ks), make_weight(ks), make_weight(ks)};
  endfunction

  // Dimension word; the upper bits carry junk half the time, the block must ignore them.
  function automatic logic [CFG_DATA_W-1:0] dim_word(logic [DIM_W-1:0] n);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'({$urandom, $urandom});
    if ($urandom_range(0, 1)) v = '0;
    v[DIM_W-1:0] = n;
    return v;
  endfunction

  // Write the selected registers in index order, then leave the write port idle.
  task automatic program_regs(input reg_image_t vals, input logic [REG_COUNT-1:0] sel);
    for (int i = 0; i < REG_COUNT; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= cfg_idx_t'(i);
        cfg_wdata <= vals[i];
        @(posedge clk);
        sb.write_reg(cfg_idx_t'(i), vals[i]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel request and hold it until accepted. Valid stays high on return.
  task automatic send_pixel(input pixel_t p);
    in_pix.valid     <= 1'b1;
    in_pix.pix_red   <= p.red;
    in_pix.pix_green <= p.green;
    in_pix.pix_blue  <= p.blue;
    in_pix.pix_alpha <= p.alpha;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_pix.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the pipeline settle.
  task automatic drain_results();
    in_pix.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send pixels in bursts until max_pixels are sent or frame_count frames have ended.
  task automatic stream(input int unsigned max_pixels, input int unsigned frame_count);
    int unsigned sent, frame_goal, burst_left, gap;
    sent       = 0;
    frame_goal = (frame_count == NO_LIMIT) ? NO_LIMIT : sb.frames_done + frame_count;
    burst_left = $urandom_range(1, 16);
    while (sent < max_pixels && sb.frames_done < frame_goal) begin
      send_pixel(make_pixel());
      sent++;
      if (sender_gaps) begin
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap        = $urandom_range(0, 4);
          // Now and then hold off until the block has delivered everything.
          if ($urandom_range(0, 23) == 0) drain_results();
          else if (gap != 0) pause_input(gap);
        end
      end
    end
  endtask

  // One 3x3 frame whose single result depends on a chosen weight and either the top-left
  // pixel on the top-left tap alone or all nine pixels on all nine taps.
  task automatic corner_frame(input logic [WGT_W-1:0] wgt, input bit every_tap,
                              input pixel_t corner);
    reg_image_t            vals;
    logic [REG_COUNT-1:0]  sel;
    foreach (vals[i]) vals[i] = '0;
    vals[CFG_KERN_TOP] = every_tap ? {WIN_SIDE{wgt}} : {{(2*WGT_W){1'b0}}, wgt};
    vals[CFG_KERN_MID] = every_tap ? {WIN_SIDE{wgt}} : '0;
    vals[CFG_KERN_BOT] = vals[CFG_KERN_MID];
    sel = '0;
    sel[CFG_KERN_TOP] = 1'b1;
    sel[CFG_KERN_MID] = 1'b1;
    sel[CFG_KERN_BOT] = 1'b1;
    program_regs(vals, sel);
    send_pixel(corner);
    for (int i = 0; i < TAPS - 1; i++) send_pixel(make_pixel());
    drain_results();
  endtask

  // Result side: check every accepted result, and stall on a pattern of its own.
  initial begin : result_sink
    conv_result_t got;
    sink_mode_t   mode;
    int unsigned  seg_left, hold_left, beat;
    bit           held_once, next_ready;
    out_pix.ready <= 1'b0;
    mode      = SINK_OPEN;
    seg_left  = 0;
    hold_left = 0;
    beat      = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pix.valid && out_pix.ready) begin
        got.red       = out_pix.out_red;
        got.green     = out_pix.out_green;
        got.blue      = out_pix.out_blue;
        got.alpha     = out_pix.out_alpha;
        got.row_end   = out_pix.row_end;
        got.frame_end = out_pix.frame_end;
        sb.check_result(got);
      end
      // Once, early on, hold off long enough that the block fills and drops in_pix.ready.
      if (!held_once && sb.checked >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = sink_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        beat++;
        case (mode)
          SINK_OPEN:  next_ready = 1'b1;
          SINK_COIN:  next_ready = 1'($urandom_range(0, 1));
          SINK_LIGHT: next_ready = ($urandom_range(0, 3) != 0);
          default:    next_ready = (beat % 3 != 0);
        endcase
      end
      out_pix.ready <= next_ready;
    end
  end

  initial begin : stimulus
    reg_image_t           vals;
    logic [REG_COUNT-1:0] sel;
    int unsigned          random_start;
    kern_style_t          ks;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_LINE_WIDTH;
    cfg_wdata        <= '0;
    in_pix.valid     <= 1'b0;
    in_pix.pix_red   <= '0;
    in_pix.pix_green <= '0;
    in_pix.pix_blue  <= '0;
    in_pix.pix_alpha <= '0;
    foreach (vals[i]) vals[i] = '0;
    pix_style   = PIX_RANDOM;
    sender_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset kernel and height on a narrow frame. Stream continuously for thirteen rows and
    // part of a fourteenth, so the receiver hold-off lands while requests keep coming.
    vals[CFG_LINE_WIDTH] = dim_word(DIM_W'(START_WIDTH));
    sel = '0;
    sel[CFG_LINE_WIDTH] = 1'b1;
    program_regs(vals, sel);
    stream(START_ITEMS, NO_LIMIT);
    drain_results();

    // Shrink both dimensions mid-frame: the column counter is already past the new width
    // and the row counter past the new height, so the next pixel ends row and frame.
    vals[CFG_LINE_WIDTH] = dim_word(5);
    vals[CFG_LINE_COUNT] = dim_word(3);
    sel = '0;
    sel[CFG_LINE_WIDTH] = 1'b1;
    sel[CFG_LINE_COUNT] = 1'b1;
    program_regs(vals, sel);
    sender_gaps = 1'b1;
    stream(NO_LIMIT, 1);
    stream(NO_LIMIT, 1);
    drain_results();

    // Directed clamp and rounding corners on 3x3 frames; both sizes below range clamp to 3.
    vals[CFG_LINE_WIDTH] = dim_word(2);
    vals[CFG_LINE_COUNT] = dim_word(0);
    program_regs(vals, sel);
    // exactly 255.0 saturates, 1/256*256 gives 1, zero stays zero
    corner_frame(WGT_ONE, 1'b0, '{red: 8'd255, green: 8'd0, blue: 8'd1, alpha: 8'd255});
    // just under the top bound, fraction dropped, fraction-only sum truncates to zero
    corner_frame(WGT_UNDER, 1'b0, '{red: 8'd255, green: 8'd1, blue: 8'd128, alpha: 8'd0});
    // negative sums clamp to zero
    corner_frame(WGT_NEG_LSB, 1'b0, '{red: 8'd255, green: 8'd0, blue: 8'd1, alpha: 8'd170});
    pix_style = PIX_EXTREME;
    corner_frame(WGT_POS_MAX, 1'b1, '{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd85});
    corner_frame(WGT_NEG_MAX, 1'b1, '{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd1});

    // Oversize width and height clamp to the maximum: part of a wide first row must not
    // end the row.
    pix_style = PIX_DARK;
    vals[CFG_LINE_WIDTH] = dim_word(DIM_FIELD_MAX);
    vals[CFG_LINE_COUNT] = dim_word(DIM_FIELD_MAX);
    vals[CFG_KERN_TOP]   = make_row(KERN_SOFT);
    vals[CFG_KERN_MID]   = make_row(KERN_SOFT);
    vals[CFG_KERN_BOT]   = make_row(KERN_SOFT);
    sel = '1;
    program_regs(vals, sel);
    stream(WIDE_ITEMS, NO_LIMIT);
    drain_results();

    // Narrow to three columns: the next pixel ends the row, then nineteen more rows and part
    // of a twentieth must run without a frame end under the clamped height.
    pix_style = PIX_RANDOM;
    vals[CFG_LINE_WIDTH] = dim_word(DIM_W'(MIN_DIM));
    vals[CFG_KERN_MID]   = make_row(KERN_EDGE);
    program_regs(vals, sel);
    stream(TALL_ITEMS, NO_LIMIT);
    drain_results();

    // Cut the height back to three: the next row end closes the frame.
    vals[CFG_LINE_COUNT] = dim_word(DIM_W'(MIN_DIM));
    program_regs(vals, sel);
    stream(NO_LIMIT, 1);
    drain_results();

    // Random phases: small frames, fresh dimensions and kernel each time.
    random_start = sb.accepted;
    while (sb.accepted - random_start < RANDOM_ITEMS) begin
      vals[CFG_LINE_WIDTH] = dim_word(DIM_W'(($urandom_range(0, 11) == 0) ?
                                             $urandom_range(0, 2) : $urandom_range(3, 12)));
      vals[CFG_LINE_COUNT] = dim_word(DIM_W'(($urandom_range(0, 11) == 0) ?
                                             $urandom_range(0, 2) : $urandom_range(3, 6)));
      ks = kern_style_t'($urandom_range(0, 2));
      vals[CFG_KERN_TOP] = make_row(ks);
      vals[CFG_KERN_MID] = make_row(ks);
      vals[CFG_KERN_BOT] = make_row(ks);
      program_regs(vals, sel);
      pix_style   = pix_style_t'($urandom_range(0, 2));
      sender_gaps = ($urandom_range(0, 3) != 0);
      stream(NO_LIMIT, $urandom_range(1, 3));
      drain_results();
    end

    // Drained above; give stray results a few more cycles to show up.
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
